### src/irfe_pkg.sv
// Shared types, codes and constants for the IR motor frame encoder.
package irfe_pkg;

   localparam int DATA_BITS  = 16;
   localparam int CNT_W      = $clog2(DATA_BITS);
   localparam int HALF_W     = 8;
   localparam int FACTOR_W   = 7;
   localparam int TAIL_W     = 15;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 8'd13;
   localparam logic [3:0]        HALF_ENTRIES      = 4'd12;

   // gap factor 1 + 2*ext for ext = 10, 21, 39
   localparam logic [FACTOR_W-1:0] FACTOR_LOW   = 7'd21;
   localparam logic [FACTOR_W-1:0] FACTOR_HIGH  = 7'd43;
   localparam logic [FACTOR_W-1:0] FACTOR_FRAME = 7'd79;

   localparam logic [DATA_BITS-1:0] BASE_BRAKE   = 16'h0480;
   localparam logic [DATA_BITS-1:0] BASE_FORWARD = 16'h0400;
   localparam logic [DATA_BITS-1:0] BASE_INC     = 16'h0640;
   localparam logic [DATA_BITS-1:0] BASE_DEC     = 16'h0650;
   localparam logic [3:0]           CHECK_SEED   = 4'hf;
   localparam logic [3:0]           REV_ORIGIN   = 4'd8;

   // CSR register index (byte address / 4)
   localparam logic [CSR_ADDR_W-3:0] CSR_IDX_HALF_PERIOD = 1'b0;

   typedef enum logic [2:0] {
      FUNC_BRAKE   = 3'd0,
      FUNC_FORWARD = 3'd1,
      FUNC_REVERSE = 3'd2,
      FUNC_INC     = 3'd3,
      FUNC_DEC     = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      SYM_START = 2'd0,
      SYM_ZERO  = 2'd1,
      SYM_ONE   = 2'd2,
      SYM_STOP  = 2'd3
   } sym_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_BITS,
      ST_STOP
   } seq_state_type;

   typedef struct packed {
      sym_kind_type kind;
      logic         last;
   } sym_type;

   typedef struct packed {
      logic busy;
      logic ending;
   } seq_status_type;

   function automatic logic [FACTOR_W-1:0] tail_factor(input sym_kind_type kind);
      logic [FACTOR_W-1:0] f;
      unique case (kind)
         SYM_ZERO: f = FACTOR_LOW;
         SYM_ONE:  f = FACTOR_HIGH;
         default:  f = FACTOR_FRAME;
      endcase
      return f;
   endfunction

endpackage

### src/irfe_word_build.sv
// Frame word assembly: base opcode, control bits and check nibble.
module irfe_word_build
   import irfe_pkg::*;
(
   input  logic [2:0]           func,
   input  logic                 toggle,
   input  logic [1:0]           channel,
   input  logic                 output_sel,
   input  logic [2:0]           step,
   output logic [DATA_BITS-1:0] word,
   output logic                 word_ok
);

   logic [DATA_BITS-1:0] base;
   logic [DATA_BITS-1:0] raw;
   logic [3:0]           rev_step;
   logic [3:0]           chk;

   assign rev_step = REV_ORIGIN - {1'b0, step};

   always_comb begin
      word_ok = 1'b1;
      unique case (func)
         FUNC_BRAKE:   base = BASE_BRAKE;
         FUNC_FORWARD: base = BASE_FORWARD | {9'd0, step, 4'd0};
         FUNC_REVERSE: base = BASE_BRAKE | {8'd0, rev_step, 4'd0};
         FUNC_INC:     base = BASE_INC;
         FUNC_DEC:     base = BASE_DEC;
         default: begin
            base    = BASE_DEC;
            word_ok = 1'b0;
         end
      endcase
   end

   assign raw = base | {toggle, 15'd0} | {2'd0, channel, 12'd0} | {7'd0, output_sel, 8'd0};
   assign chk = CHECK_SEED ^ raw[15:12] ^ raw[11:8] ^ raw[7:4];
   assign word = {raw[15:4], chk};

endmodule

### src/irfe_tail_mul.sv
// Gap length unit: half period times the symbol's gap factor.
module irfe_tail_mul
   import irfe_pkg::*;
(
   input  logic [HALF_W-1:0] half_period,
   input  sym_kind_type      kind,
   output logic [TAIL_W-1:0] tail_us
);

   logic [FACTOR_W-1:0] factor;

   assign factor  = tail_factor(kind);
   assign tail_us = TAIL_W'(half_period) * TAIL_W'(factor);

endmodule

### src/irfe_sequencer.sv
// Symbol sequencer: start, data bits MSB first from a shift register, stop.
module irfe_sequencer
   import irfe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic [DATA_BITS-1:0] word,
   input  logic                 advance,
   output sym_type              sym,
   output seq_status_type       status,
   output logic [DATA_BITS-1:0] frame_hold
);

   seq_state_type        state_ff, state_in;
   logic [DATA_BITS-1:0] shift_ff, shift_in;
   logic [DATA_BITS-1:0] hold_ff, hold_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         shift_ff <= '0;
         hold_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         shift_ff <= shift_in;
         hold_ff  <= hold_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      shift_in      = shift_ff;
      hold_in       = hold_ff;
      sym.kind      = SYM_START;
      sym.last      = 1'b0;
      status.busy   = (state_ff != ST_IDLE);
      status.ending = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (load) begin
               state_in = ST_START;
               shift_in = word;
               hold_in  = word;
            end
         end
         ST_START: begin
            if (advance) begin
               state_in = ST_BITS;
               cnt_in   = '0;
            end
         end
         ST_BITS: begin
            if (shift_ff[DATA_BITS-1]) begin
               sym.kind = SYM_ONE;
            end else begin
               sym.kind = SYM_ZERO;
            end
            if (advance) begin
               shift_in = {shift_ff[DATA_BITS-2:0], 1'b0};
               cnt_in   = cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(DATA_BITS - 1)) begin
                  state_in = ST_STOP;
               end
            end
         end
         ST_STOP: begin
            sym.kind      = SYM_STOP;
            sym.last      = 1'b1;
            status.ending = advance;
            if (advance) begin
               if (load) begin
                  state_in = ST_START;
                  shift_in = word;
                  hold_in  = word;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign frame_hold  = hold_ff;

`ifndef SYNTHESIS
   a_stop_follows_bits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BITS && advance && cnt_ff == CNT_W'(DATA_BITS - 1))
      |=> (state_ff == ST_STOP))
      else $error("stop symbol did not follow last data bit");

   a_stop_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STOP && advance) |=> (state_ff == ST_IDLE || state_ff == ST_START))
      else $error("sequencer left stop into a wrong state");
`endif

endmodule

### src/ir_motor_frame_encoder_core.sv
// Top level of the IR motor frame encoder: CSR, sequencer, gap unit and result register.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  func, toggle, channel, output_sel, step
//   rsp_      out        rsp_valid/rsp_stall  symbol_kind, carrier_half_periods,
//                                             tail_space_us, frame_word, last
//   csr_      in/out     APB psel/penable     half_period_us at byte address 0
//
// One valid request gives 18 symbols, one per cycle while rsp_stall is low, so a
// new request is taken only when the sequencer is idle or issuing a stop symbol.
// A request with an unused command code is taken and gives nothing.
// rsp_stall holds the result register and pauses the sequencer; req_stall is high
// while a frame is in flight and drops in the cycle the stop symbol is registered.
// Reset is synchronous: sequencer idle, no result pending, half period back to 13.
module ir_motor_frame_encoder_core
   import irfe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [2:0]            req_func,
   input  logic                  req_toggle,
   input  logic [1:0]            req_channel,
   input  logic                  req_output_sel,
   input  logic [2:0]            req_step,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_symbol_kind,
   output logic [3:0]            rsp_carrier_half_periods,
   output logic [TAIL_W-1:0]     rsp_tail_space_us,
   output logic [DATA_BITS-1:0]  rsp_frame_word,
   output logic                  rsp_last,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [HALF_W-1:0]    half_ff, half_in;
   logic                 csr_hit;

   logic [DATA_BITS-1:0] word;
   logic                 word_ok;
   logic                 req_take;
   logic                 load;
   logic                 advance;
   sym_type              sym;
   seq_status_type       status;
   logic [DATA_BITS-1:0] frame_hold;
   logic [TAIL_W-1:0]    tail_us;

   logic                 rsp_valid_ff, rsp_valid_in;
   sym_kind_type         kind_ff;
   logic                 last_ff;
   logic [TAIL_W-1:0]    tail_ff;
   logic [DATA_BITS-1:0] fword_ff;

   // configuration register, byte offset bits ignored
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_HALF_PERIOD);
   assign half_in    = (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit)
                       ? csr_pwdata[HALF_W-1:0] : half_ff;
   assign csr_prdata = csr_hit ? {{(CSR_DATA_W - HALF_W){1'b0}}, half_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= HALF_PERIOD_RESET;
      end else begin
         half_ff <= half_in;
      end
   end

   irfe_word_build u_word (
      .func       (req_func),
      .toggle     (req_toggle),
      .channel    (req_channel),
      .output_sel (req_output_sel),
      .step       (req_step),
      .word       (word),
      .word_ok    (word_ok)
   );

   // sequencer steps whenever the result register is free or being emptied
   assign advance   = status.busy && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = status.busy && !status.ending;
   assign req_take  = req_valid && !req_stall;
   assign load      = req_take && word_ok;

   irfe_sequencer u_seq (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .word       (word),
      .advance    (advance),
      .sym        (sym),
      .status     (status),
      .frame_hold (frame_hold)
   );

   irfe_tail_mul u_tail (
      .half_period (half_ff),
      .kind        (sym.kind),
      .tail_us     (tail_us)
   );

   // result register
   assign rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         kind_ff  <= sym.kind;
         last_ff  <= sym.last;
         tail_ff  <= tail_us;
         fword_ff <= frame_hold;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_symbol_kind          = kind_ff;
   assign rsp_carrier_half_periods = HALF_ENTRIES;
   assign rsp_tail_space_us        = tail_ff;
   assign rsp_frame_word           = fword_ff;
   assign rsp_last                 = last_ff;

`ifndef SYNTHESIS
   a_last_is_stop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && last_ff) |-> (kind_ff == SYM_STOP))
      else $error("last flag on a symbol other than stop");

   a_load_blocks: assert property (@(posedge clock) disable iff (reset)
      load |=> req_stall)
      else $error("request not blocked after a frame was started");
`endif

endmodule
